### hw/rtl/ghtu_pkg.sv
`timescale 1ns / 1ps
package ghtu_pkg;
	localparam int TABLE_SLOTS_DEF = 64;
	localparam int SLOT_W = 12;
	localparam int CNT_W = 13;

	localparam logic [1:0] FN_LOOKUP  = 2'd0;
	localparam logic [1:0] FN_FORGET  = 2'd1;
	localparam logic [1:0] FN_RESOLVE = 2'd2;
	localparam logic [1:0] FN_RESET   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_STALE    = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [2:0] WR_NONE  = 3'd0;
	localparam logic [2:0] WR_ALLOC = 3'd1;
	localparam logic [2:0] WR_INCR  = 3'd2;
	localparam logic [2:0] WR_SUB   = 3'd3;
	localparam logic [2:0] WR_CLEAR = 3'd4;

	localparam logic [63:0] ROOT_HANDLE = 64'd1;
	localparam logic [63:0] REFS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic [63:0]       hit_refs;
		logic              found;
		logic [SLOT_W-1:0] found_slot;
		logic [63:0]       found_refs;
		logic [31:0]       found_gen;
		logic              free_ok;
		logic [SLOT_W-1:0] free_idx;
		logic [31:0]       free_gen;
		logic [CNT_W-1:0]  live;
	} pkt_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [SLOT_W-1:0] slot;
		logic [63:0]       refs;
		logic [31:0]       gen;
	} wr_t;
endpackage

### hw/rtl/ghtu_cell.sv
`timescale 1ns / 1ps
module ghtu_cell #(
	parameter int IDX = 0,
	parameter int TABLE_SLOTS = ghtu_pkg::TABLE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ghtu_pkg::pkt_t                pkt_in,
	output ghtu_pkg::pkt_t                pkt_out,
	input  logic [63:0]                   node_ref,
	input  logic [63:0]                   dev_key,
	input  logic [63:0]                   ino_key,
	input  logic [$clog2(TABLE_SLOTS+1)-1:0] cap,
	input  ghtu_pkg::wr_t                 wr
);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [31:0] LOW = 32'(IDX + 1);
	localparam logic [ghtu_pkg::SLOT_W-1:0] ME = ghtu_pkg::SLOT_W'(IDX);
	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic        valid_q;
	logic [31:0] gen_q;
	logic [63:0] refs_q;
	logic [63:0] dev_q;
	logic [63:0] ino_q;
	ghtu_pkg::pkt_t pkt_q;
	ghtu_pkg::pkt_t nxt;
	logic in_cap, hit, key_eq, sel;

	assign in_cap = IDX_C < cap;
	assign key_eq = (dev_q == dev_key) && (ino_q == ino_key);
	assign hit = ((IDX == 0) && (node_ref == ghtu_pkg::ROOT_HANDLE)) ||
		((IDX != 0) && (node_ref[31:0] == LOW) && (node_ref[63:32] != 32'd0) &&
		in_cap && valid_q && (gen_q == node_ref[63:32]));
	assign sel = (wr.slot == ME);

	always_comb begin
		nxt = pkt_in;
		if (hit) begin
			nxt.hit = 1'b1;
			nxt.hit_slot = ME;
			nxt.hit_refs = refs_q;
		end
		if ((IDX != 0) && in_cap && !pkt_in.found) begin
			if (valid_q && key_eq) begin
				nxt.found = 1'b1;
				nxt.found_slot = ME;
				nxt.found_refs = refs_q;
				nxt.found_gen = gen_q;
			end else if (!valid_q && !pkt_in.free_ok) begin
				nxt.free_ok = 1'b1;
				nxt.free_idx = ME;
				nxt.free_gen = gen_q;
			end
		end
		if (valid_q && in_cap) begin
			nxt.live = pkt_in.live + ghtu_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= nxt;
		end
	end
	assign pkt_out = pkt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= (IDX == 0);
			gen_q <= (IDX == 0) ? 32'd1 : 32'd0;
			refs_q <= (IDX == 0) ? ghtu_pkg::REFS_MAX : 64'd0;
			dev_q <= '0;
			ino_q <= '0;
		end else begin
			case (wr.kind)
				ghtu_pkg::WR_ALLOC: begin
					if (sel) begin
						valid_q <= 1'b1;
						gen_q <= wr.gen;
						refs_q <= 64'd1;
						dev_q <= dev_key;
						ino_q <= ino_key;
					end
				end
				ghtu_pkg::WR_INCR: begin
					if (sel) refs_q <= wr.refs;
				end
				ghtu_pkg::WR_SUB: begin
					if (sel) begin
						refs_q <= wr.refs;
						if (wr.refs == 64'd0) begin
							valid_q <= 1'b0;
							dev_q <= '0;
							ino_q <= '0;
						end
					end
				end
				ghtu_pkg::WR_CLEAR: begin
					if (IDX != 0) begin
						valid_q <= 1'b0;
						refs_q <= '0;
						dev_q <= '0;
						ino_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### hw/rtl/generation_tagged_handle_table_unit.sv
`timescale 1ns / 1ps
// every operation: the start beat is registered into go_q, then a scan packet walks the row of slot cells
// one cell per cycle, then the table is updated and the result is shown on done for one cycle; busy stays high
// until the update, the receiver cannot stall results, and config writes are taken any time
module generation_tagged_handle_table_unit #(
	parameter int TABLE_SLOTS = ghtu_pkg::TABLE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [63:0] node_ref,
	input  logic [63:0] dev_key,
	input  logic [63:0] ino_key,
	input  logic [63:0] forget_count,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] handle_out,
	output logic [5:0]  slot_index,
	output logic [63:0] ref_count,
	output logic [6:0]  live_entries
);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int VW = (CW > 7) ? CW : 7;
	localparam logic [VW-1:0] TS_V = VW'(TABLE_SLOTS);

	logic [6:0]  slots_q;
	logic [1:0]  func_q;
	logic [63:0] ref_q, dev_q, ino_q, cnt_q;
	logic        busy_q, go_q;
	logic [VW-1:0] siu;
	logic [CW-1:0] cap;
	ghtu_pkg::pkt_t chain [0:TABLE_SLOTS];
	ghtu_pkg::pkt_t p;
	ghtu_pkg::wr_t wr;
	logic [2:0]  st_n;
	logic [63:0] h_n, r_n;
	logic [ghtu_pkg::SLOT_W-1:0] s_n;
	logic [ghtu_pkg::CNT_W-1:0] l_n;
	logic [31:0] g_n;
	logic [63:0] sub_n;
	logic accept;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, slots_q} : 32'd0;
	assign accept = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 7'd64;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			slots_q <= pwdata[6:0];
		end
	end

	assign siu = VW'(slots_q);
	assign cap = (siu < VW'(2)) ? CW'(2) : (siu > TS_V) ? CW'(TABLE_SLOTS) : CW'(siu);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			ref_q <= node_ref;
			dev_q <= dev_key;
			ino_q <= ino_key;
			cnt_q <= forget_count;
		end
	end

	always_comb begin
		chain[0] = '0;
		chain[0].valid = go_q;
	end

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		ghtu_cell #(.IDX(g), .TABLE_SLOTS(TABLE_SLOTS)) u_cell (
			.clk(clk), .arst_n(arst_n), .pkt_in(chain[g]), .pkt_out(chain[g+1]),
			.node_ref(ref_q), .dev_key(dev_q), .ino_key(ino_q), .cap(cap), .wr(wr)
		);
	end

	assign p = chain[TABLE_SLOTS];
	assign sub_n = p.hit_refs - cnt_q;

	always_comb begin
		st_n = ghtu_pkg::ST_OK;
		h_n = '0;
		r_n = '0;
		s_n = '0;
		l_n = p.live;
		g_n = p.free_gen + 32'd1;
		if (g_n == 32'd0) g_n = 32'd1;
		wr = '0;
		case (func_q)
			ghtu_pkg::FN_LOOKUP: begin
				if (!p.hit) begin
					st_n = ghtu_pkg::ST_STALE;
				end else if (p.found) begin
					if (p.found_refs == ghtu_pkg::REFS_MAX) begin
						st_n = ghtu_pkg::ST_OVERFLOW;
					end else begin
						s_n = p.found_slot;
						r_n = p.found_refs + 64'd1;
						h_n = {p.found_gen, 32'(p.found_slot) + 32'd1};
						wr.kind = ghtu_pkg::WR_INCR;
						wr.slot = p.found_slot;
						wr.refs = r_n;
					end
				end else if (!p.free_ok) begin
					st_n = ghtu_pkg::ST_FULL;
				end else begin
					s_n = p.free_idx;
					r_n = 64'd1;
					h_n = {g_n, 32'(p.free_idx) + 32'd1};
					l_n = p.live + ghtu_pkg::CNT_W'(1);
					wr.kind = ghtu_pkg::WR_ALLOC;
					wr.slot = p.free_idx;
					wr.gen = g_n;
				end
			end
			ghtu_pkg::FN_FORGET: begin
				if ((cnt_q == 64'd0) || (ref_q == ghtu_pkg::ROOT_HANDLE)) begin
					st_n = ghtu_pkg::ST_INVALID;
				end else if (!p.hit) begin
					st_n = ghtu_pkg::ST_STALE;
				end else if (cnt_q > p.hit_refs) begin
					st_n = ghtu_pkg::ST_INVALID;
				end else begin
					s_n = p.hit_slot;
					r_n = sub_n;
					if (sub_n == 64'd0) l_n = p.live - ghtu_pkg::CNT_W'(1);
					wr.kind = ghtu_pkg::WR_SUB;
					wr.slot = p.hit_slot;
					wr.refs = sub_n;
				end
			end
			ghtu_pkg::FN_RESOLVE: begin
				if (!p.hit) begin
					st_n = ghtu_pkg::ST_STALE;
				end else begin
					s_n = p.hit_slot;
					r_n = p.hit_refs;
				end
			end
			default: begin
				l_n = ghtu_pkg::CNT_W'(1);
				wr.kind = ghtu_pkg::WR_CLEAR;
			end
		endcase
		if (!p.valid) wr.kind = ghtu_pkg::WR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			go_q <= 1'b0;
			done <= 1'b0;
		end else begin
			go_q <= accept;
			done <= p.valid;
			if (accept) busy_q <= 1'b1;
			else if (p.valid) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (p.valid) begin
			status <= st_n;
			handle_out <= h_n;
			slot_index <= 6'(s_n);
			ref_count <= r_n;
			live_entries <= 7'(l_n);
		end
	end
endmodule
